// File: rtl/core/iis_pkg.sv
`timescale 1ns / 1ps

package iis_pkg;

	localparam int PIX_W     = 8;
	localparam int PIX_MAX   = 255;
	localparam int SQR_W     = 2 * PIX_W;
	localparam int SUM_W     = 32;
	localparam int SQ_W      = 40;
	localparam int CNT_W     = 25;
	localparam int RUN_SUM_W = 20;
	localparam int RUN_SQ_W  = 28;
	localparam int RUN_CNT_W = 13;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;

	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;

	localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = CFG_W'(4096);
	localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = CFG_W'(4096);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_MASK_ENABLE  = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_value;
		logic             alpha_valid;
	} pix_item_t;

	typedef struct packed {
		logic [SUM_W-1:0] area_sum;
		logic [SQ_W-1:0]  area_square_sum;
		logic [CNT_W-1:0] area_count;
		logic             frame_last;
	} res_item_t;

	// Running row sums of one pixel plus its position flags.
	typedef struct packed {
		logic [RUN_SUM_W-1:0] sum;
		logic [RUN_SQ_W-1:0]  sq;
		logic [RUN_CNT_W-1:0] cnt;
		logic                 first_row;
		logic                 frame_last;
	} run_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [SQ_W-1:0]  sq;
		logic [CNT_W-1:0] cnt;
	} line_entry_t;

endpackage

// File: rtl/core/iis_if.sv
`timescale 1ns / 1ps

interface iis_pix_if import iis_pkg::*; ();
	logic      valid;
	logic      ready;
	pix_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface iis_res_if import iis_pkg::*; ();
	logic      valid;
	logic      ready;
	res_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/iis_scan.sv
`timescale 1ns / 1ps

module iis_scan import iis_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	localparam int XW = $clog2(MAX_WIDTH),
	localparam int YW = $clog2(MAX_HEIGHT)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             acc,
	input  logic             s2_ld,
	input  logic [PIX_W-1:0] pixel_value,
	input  logic             alpha_valid,
	input  logic [CFG_W-1:0] image_width,
	input  logic [CFG_W-1:0] image_height,
	input  logic             mask_enable,
	output logic [XW-1:0]    x_rd,
	output logic [XW-1:0]    x_s1,
	output run_t             run_s1,
	output logic             valid_s1
);

	logic [XW-1:0]        col_q;
	logic [YW-1:0]        row_q;
	logic [RUN_SUM_W-1:0] sum_q;
	logic [RUN_SQ_W-1:0]  sq_q;
	logic [RUN_CNT_W-1:0] cnt_q;

	logic [XW-1:0]        w_last;
	logic [YW-1:0]        h_last;
	logic [XW-1:0]        x;
	logic [YW-1:0]        y;
	logic                 masked;
	logic [PIX_W-1:0]     pix;
	logic [SQR_W-1:0]     pix_sq;
	logic                 last_col;
	logic                 last_row;
	logic [RUN_SUM_W-1:0] sum_n;
	logic [RUN_SQ_W-1:0]  sq_n;
	logic [RUN_CNT_W-1:0] cnt_n;

	always_comb begin
		if (image_width == '0) begin
			w_last = '0;
		end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
			w_last = XW'(MAX_WIDTH - 1);
		end else begin
			w_last = XW'(image_width - 1'b1);
		end
		if (image_height == '0) begin
			h_last = '0;
		end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
			h_last = YW'(MAX_HEIGHT - 1);
		end else begin
			h_last = YW'(image_height - 1'b1);
		end
	end

	assign x        = (col_q > w_last) ? w_last : col_q;
	assign y        = (row_q > h_last) ? h_last : row_q;
	assign last_col = (x == w_last);
	assign last_row = (y == h_last);
	assign x_rd     = x;

	assign masked = mask_enable && !alpha_valid;
	assign pix    = masked ? '0 : pixel_value;
	assign pix_sq = pix * pix;

	always_comb begin
		if (x == '0) begin
			sum_n = RUN_SUM_W'(pix);
			sq_n  = RUN_SQ_W'(pix_sq);
			cnt_n = RUN_CNT_W'(!masked);
		end else begin
			sum_n = sum_q + RUN_SUM_W'(pix);
			sq_n  = sq_q + RUN_SQ_W'(pix_sq);
			cnt_n = cnt_q + RUN_CNT_W'(!masked);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			sum_q    <= '0;
			sq_q     <= '0;
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (acc) begin
				sum_q <= sum_n;
				sq_q  <= sq_n;
				cnt_q <= cnt_n;
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : y + 1'b1;
				end else begin
					col_q <= x + 1'b1;
					row_q <= y;
				end
				valid_s1 <= 1'b1;
			end else if (s2_ld) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			x_s1              <= x;
			run_s1.sum        <= sum_n;
			run_s1.sq         <= sq_n;
			run_s1.cnt        <= cnt_n;
			run_s1.first_row  <= (y == '0);
			run_s1.frame_last <= last_col && last_row;
		end
	end

endmodule

// File: rtl/core/iis_line.sv
`timescale 1ns / 1ps

module iis_line import iis_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	localparam int XW = $clog2(MAX_WIDTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          acc,
	input  logic          s2_ld,
	input  logic          res_ready,
	input  logic [XW-1:0] x_rd,
	input  logic [XW-1:0] x_s1,
	input  run_t          run_s1,
	output res_item_t     res_s2,
	output logic          valid_s2
);

	line_entry_t mem [MAX_WIDTH];
	line_entry_t rd_q;
	logic        fwd_q;
	line_entry_t above;
	line_entry_t fwd_val;
	line_entry_t total;

	// The item leaving stage one writes its column in the same cycle that the
	// next item reads; when the columns match, the result register holds the
	// newer value.
	always_ff @(posedge clk) begin
		if (acc) begin
			rd_q  <= mem[x_rd];
			fwd_q <= s2_ld && (x_s1 == x_rd);
		end
		if (s2_ld) begin
			mem[x_s1] <= total;
		end
	end

	assign fwd_val.sum = res_s2.area_sum;
	assign fwd_val.sq  = res_s2.area_square_sum;
	assign fwd_val.cnt = res_s2.area_count;

	always_comb begin
		if (run_s1.first_row) begin
			above = '0;
		end else if (fwd_q) begin
			above = fwd_val;
		end else begin
			above = rd_q;
		end
		total.sum = above.sum + SUM_W'(run_s1.sum);
		total.sq  = above.sq + SQ_W'(run_s1.sq);
		total.cnt = above.cnt + CNT_W'(run_s1.cnt);
	end

	always_ff @(posedge clk) begin
		if (s2_ld) begin
			res_s2.area_sum        <= total.sum;
			res_s2.area_square_sum <= total.sq;
			res_s2.area_count      <= total.cnt;
			res_s2.frame_last      <= run_s1.frame_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ld) begin
			valid_s2 <= 1'b1;
		end else if (res_ready) begin
			valid_s2 <= 1'b0;
		end
	end

endmodule

// File: rtl/core/integral_image_sum_sqsum_count_top.sv
`timescale 1ns / 1ps
// A pixel's result passes the stage-one register and then the result register
// before it is offered on res.
// Throughput: one pixel per cycle, set by the line store with one read and one
// write port, read at accept and written one stage later; output stalls back up the pipe.
// Reset clears position, running row sums and valid flags and loads the configuration reset values;
// the line store is not cleared, as the first row of a frame never uses it.

module integral_image_sum_sqsum_count_top import iis_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	iis_pix_if.sink              pix,
	iis_res_if.source            res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int XW = $clog2(MAX_WIDTH);

	logic [CFG_W-1:0] image_width_q;
	logic [CFG_W-1:0] image_height_q;
	logic             mask_enable_q;

	logic          acc;
	logic          s2_ld;
	logic          valid_s1;
	logic          valid_s2;
	logic [XW-1:0] x_rd;
	logic [XW-1:0] x_s1;
	run_t          run_s1;
	res_item_t     res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= RST_IMAGE_WIDTH;
			image_height_q <= RST_IMAGE_HEIGHT;
			mask_enable_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_IMAGE_WIDTH: begin
					image_width_q <= cfg_data;
				end
				REG_IMAGE_HEIGHT: begin
					image_height_q <= cfg_data;
				end
				REG_MASK_ENABLE: begin
					mask_enable_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign s2_ld     = valid_s1 && (!valid_s2 || res.ready);
	assign pix.ready = !valid_s1 || s2_ld;
	assign acc       = pix.valid && pix.ready;
	assign res.valid = valid_s2;
	assign res.data  = res_s2;

	iis_scan #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.acc          (acc),
		.s2_ld        (s2_ld),
		.pixel_value  (pix.data.pixel_value),
		.alpha_valid  (pix.data.alpha_valid),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.mask_enable  (mask_enable_q),
		.x_rd         (x_rd),
		.x_s1         (x_s1),
		.run_s1       (run_s1),
		.valid_s1     (valid_s1)
	);

	iis_line #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.s2_ld     (s2_ld),
		.res_ready (res.ready),
		.x_rd      (x_rd),
		.x_s1      (x_s1),
		.run_s1    (run_s1),
		.res_s2    (res_s2),
		.valid_s2  (valid_s2)
	);

endmodule

// File: rtl/core/iis_checker.sv
`timescale 1ns / 1ps

module iis_checker import iis_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      pix_valid,
	input logic      pix_ready,
	input logic      res_valid,
	input logic      res_ready,
	input res_item_t res_data
);

	// A stalled result keeps its transaction unchanged.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	// With no result waiting, the pipeline always has room for a pixel.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> pix_ready)
		else $error("input stalled with empty output");

	// A rectangle with no counted pixel carries no sum.
	a_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.area_count == '0 |->
			res_data.area_sum == '0 && res_data.area_square_sum == '0)
		else $error("nonzero sum with zero count");

	// Each counted pixel adds at most full scale to the sum.
	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |->
			33'(res_data.area_sum) <= 33'(res_data.area_count) * 33'(PIX_MAX))
		else $error("sum exceeds count times full scale");

	// A squared gray level is never below the level itself.
	a_square_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> SQ_W'(res_data.area_sum) <= res_data.area_square_sum)
		else $error("square sum below sum");

endmodule

bind integral_image_sum_sqsum_count_top iis_checker u_iis_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pix.valid),
	.pix_ready (pix.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import iis_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_PIXELS = 1050;
	localparam int XW = $clog2(DEF_MAX_WIDTH);

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_data;

	iis_pix_if pix_ch ();
	iis_res_if res_ch ();

	integral_image_sum_sqsum_count_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix      (pix_ch),
		.res      (res_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// Predicted block state.
	logic [CFG_W-1:0]     img_width = RST_IMAGE_WIDTH;
	logic [CFG_W-1:0]     img_height = RST_IMAGE_HEIGHT;
	logic                 mask_on = 1'b0;
	int unsigned          col_pos = 0;
	int unsigned          row_pos = 0;
	logic [RUN_SUM_W-1:0] run_sum = '0;
	logic [RUN_SQ_W-1:0]  run_sq = '0;
	logic [RUN_CNT_W-1:0] run_cnt = '0;
	logic [SUM_W-1:0]     line_sum [DEF_MAX_WIDTH];
	logic [SQ_W-1:0]      line_sq [DEF_MAX_WIDTH];
	logic [CNT_W-1:0]     line_cnt [DEF_MAX_WIDTH];
	bit                   line_written [DEF_MAX_WIDTH];

	res_item_t   expected_integrals [$];
	int unsigned mismatch_count = 0;
	int unsigned src_gap_max = 3;
	int unsigned sink_gap_max = 3;
	int unsigned sink_hold = 0;
	int unsigned idle_cycles = 0;

	function automatic int unsigned effective_size(logic [CFG_W-1:0] raw, int unsigned limit);
		if (raw == 0)
			return 1;
		if (raw > limit)
			return limit;
		return 32'(raw);
	endfunction

	function automatic res_item_t integrate_pixel(logic [PIX_W-1:0] value, logic alpha);
		int unsigned      w;
		int unsigned      h;
		int unsigned      x;
		logic [PIX_W-1:0] p;
		logic             counted;
		logic [SUM_W-1:0] s;
		logic [SQ_W-1:0]  q;
		logic [CNT_W-1:0] c;
		res_item_t        r;
		w = effective_size(img_width, DEF_MAX_WIDTH);
		h = effective_size(img_height, DEF_MAX_HEIGHT);
		p = value;
		counted = 1'b1;
		if (mask_on && !alpha) begin
			p = '0;
			counted = 1'b0;
		end
		if (col_pos >= w)
			col_pos = w - 1;
		if (row_pos >= h)
			row_pos = h - 1;
		x = col_pos;
		if (x == 0) begin
			run_sum = '0;
			run_sq = '0;
			run_cnt = '0;
		end
		run_sum = run_sum + RUN_SUM_W'(p);
		run_sq = run_sq + RUN_SQ_W'(p) * RUN_SQ_W'(p);
		run_cnt = run_cnt + RUN_CNT_W'(counted);
		s = SUM_W'(run_sum);
		q = SQ_W'(run_sq);
		c = CNT_W'(run_cnt);
		if (row_pos != 0) begin
			s = s + line_sum[x[XW-1:0]];
			q = q + line_sq[x[XW-1:0]];
			c = c + line_cnt[x[XW-1:0]];
		end
		line_sum[x[XW-1:0]] = s;
		line_sq[x[XW-1:0]] = q;
		line_cnt[x[XW-1:0]] = c;
		line_written[x[XW-1:0]] = 1'b1;
		r.area_sum = s;
		r.area_square_sum = q;
		r.area_count = c;
		r.frame_last = (x + 1 >= w) && (row_pos + 1 >= h);
		if (x + 1 >= w) begin
			col_pos = 0;
			row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
		end else begin
			col_pos = x + 1;
		end
		return r;
	endfunction

	// A size change must never make a later row read a line entry that no row wrote.
	function automatic bit resize_is_safe(logic [CFG_W-1:0] w_raw, logic [CFG_W-1:0] h_raw);
		int unsigned w;
		int unsigned h;
		int unsigned c;
		int unsigned r;
		int unsigned x;
		w = effective_size(w_raw, DEF_MAX_WIDTH);
		h = effective_size(h_raw, DEF_MAX_HEIGHT);
		c = (col_pos >= w) ? w - 1 : col_pos;
		r = (row_pos >= h) ? h - 1 : row_pos;
		if (r == 0)
			return 1'b1;
		for (x = c; x < w; x++)
			if (!line_written[x[XW-1:0]])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic int unsigned pixels_to_frame_end();
		int unsigned w;
		int unsigned h;
		int unsigned c;
		int unsigned r;
		w = effective_size(img_width, DEF_MAX_WIDTH);
		h = effective_size(img_height, DEF_MAX_HEIGHT);
		c = (col_pos >= w) ? w - 1 : col_pos;
		r = (row_pos >= h) ? h - 1 : row_pos;
		return (h - 1 - r) * w + (w - c);
	endfunction

	function automatic logic [CFG_W-1:0] pick_size(int unsigned common_max, int unsigned mid_max);
		int unsigned roll;
		roll = $urandom_range(99, 0);
		if (roll < 70)
			return CFG_W'($urandom_range(common_max, 1));
		if (roll < 85)
			return CFG_W'($urandom_range(mid_max, common_max + 1));
		if (roll < 95)
			return CFG_W'($urandom_range(1, 0));
		return CFG_W'($urandom_range(8191, 4096));
	endfunction

	function automatic logic [PIX_W-1:0] pick_pixel();
		case ($urandom_range(7, 0))
			0: return '0;
			1: return PIX_W'(PIX_MAX);
			default: return PIX_W'($urandom_range(PIX_MAX, 0));
		endcase
	endfunction

	function automatic int unsigned pick_gap_max();
		case ($urandom_range(2, 0))
			0: return 0;
			1: return 3;
			default: return 16;
		endcase
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		case (idx)
			REG_IMAGE_WIDTH: img_width = value;
			REG_IMAGE_HEIGHT: img_height = value;
			REG_MASK_ENABLE: mask_on = value[0];
			default: ;
		endcase
	endtask

	task automatic send_pixel(logic [PIX_W-1:0] value, logic alpha);
		int unsigned gap;
		pix_item_t   item;
		gap = $urandom_range(src_gap_max, 0);
		item.pixel_value = value;
		item.alpha_valid = alpha;
		if (gap != 0) begin
			pix_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_ch.data <= item;
		pix_ch.valid <= 1'b1;
		@(posedge clk);
		while (!pix_ch.ready) @(posedge clk);
		expected_integrals.push_back(integrate_pixel(value, alpha));
		@(negedge clk);
	endtask

	task automatic send_random_pixels(int unsigned count);
		repeat (count) send_pixel(pick_pixel(), 1'($urandom_range(1, 0)));
	endtask

	task automatic drain_results();
		pix_ch.valid <= 1'b0;
		while (expected_integrals.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic check_result(res_item_t got);
		res_item_t want;
		if (expected_integrals.size() == 0) begin
			mismatch_count++;
			$display("%0t: unexpected transaction sum=%0d sqsum=%0d count=%0d last=%0d",
				$time, got.area_sum, got.area_square_sum, got.area_count, got.frame_last);
			return;
		end
		want = expected_integrals.pop_front();
		if (got.area_sum !== want.area_sum) begin
			mismatch_count++;
			$display("%0t: area_sum expected %0d got %0d", $time, want.area_sum, got.area_sum);
		end
		if (got.area_square_sum !== want.area_square_sum) begin
			mismatch_count++;
			$display("%0t: area_square_sum expected %0d got %0d",
				$time, want.area_square_sum, got.area_square_sum);
		end
		if (got.area_count !== want.area_count) begin
			mismatch_count++;
			$display("%0t: area_count expected %0d got %0d", $time, want.area_count, got.area_count);
		end
		if (got.frame_last !== want.frame_last) begin
			mismatch_count++;
			$display("%0t: frame_last expected %0d got %0d", $time, want.frame_last, got.frame_last);
		end
	endtask

	// Starts at the reset geometry, then shrinks the frame while a row is in progress.
	task automatic test_default_geometry();
		send_pixel('0, 1'b0);
		send_pixel(PIX_W'(PIX_MAX), 1'b1);
		send_pixel(8'd1, 1'b0);
		send_pixel(8'd128, 1'b1);
		send_pixel(PIX_W'(PIX_MAX), 1'b0);
		send_pixel('0, 1'b1);
		send_pixel(8'd254, 1'b0);
		send_pixel(8'd127, 1'b1);
		drain_results();
		write_reg(REG_IMAGE_WIDTH, CFG_W'(4));
		write_reg(REG_IMAGE_HEIGHT, CFG_W'(2));
		send_random_pixels(5);
		drain_results();
	endtask

	task automatic test_masking();
		write_reg(REG_MASK_ENABLE, CFG_W'(1));
		write_reg(REG_IMAGE_WIDTH, CFG_W'(3));
		write_reg(REG_IMAGE_HEIGHT, CFG_W'(2));
		send_pixel(PIX_W'(PIX_MAX), 1'b0);
		send_pixel(PIX_W'(PIX_MAX), 1'b1);
		send_pixel('0, 1'b1);
		send_pixel(PIX_W'(PIX_MAX), 1'b1);
		send_pixel(8'd7, 1'b0);
		send_pixel(PIX_W'(PIX_MAX), 1'b1);
		drain_results();
	endtask

	task automatic test_size_limits();
		write_reg(REG_IMAGE_WIDTH, '0);
		write_reg(REG_IMAGE_HEIGHT, '0);
		send_random_pixels(2);
		drain_results();
		write_reg(REG_IMAGE_WIDTH, CFG_W'(1));
		write_reg(REG_IMAGE_HEIGHT, CFG_W'(4096));
		send_random_pixels(5);
		drain_results();
		write_reg(REG_IMAGE_HEIGHT, CFG_W'(8191));
		send_random_pixels(2);
		drain_results();
		write_reg(REG_IMAGE_HEIGHT, CFG_W'(3));
		send_random_pixels(1);
		drain_results();
		write_reg(REG_MASK_ENABLE, '0);
		write_reg(REG_IMAGE_WIDTH, CFG_W'(8191));
		write_reg(REG_IMAGE_HEIGHT, CFG_W'(1));
		src_gap_max = 0;
		sink_gap_max = 0;
		send_random_pixels(100);
		drain_results();
	endtask

	// The result side holds off long enough for the pipeline to back up into the input.
	task automatic test_output_stall();
		write_reg(REG_IMAGE_WIDTH, CFG_W'(5));
		write_reg(REG_IMAGE_HEIGHT, CFG_W'(3));
		src_gap_max = 0;
		sink_gap_max = 3;
		sink_hold = 200;
		send_random_pixels(30);
		drain_results();
	endtask

	task automatic test_random_frames(int unsigned pixel_goal);
		int unsigned      sent;
		int unsigned      batch;
		int unsigned      frame_pixels;
		logic [CFG_W-1:0] new_w;
		logic [CFG_W-1:0] new_h;
		sent = 0;
		while (sent < pixel_goal) begin
			drain_results();
			new_w = pick_size(8, 40);
			new_h = pick_size(6, 20);
			if ($urandom_range(3, 0) != 0 && resize_is_safe(new_w, new_h)) begin
				write_reg(REG_IMAGE_WIDTH, new_w);
				write_reg(REG_IMAGE_HEIGHT, new_h);
			end
			if ($urandom_range(1, 0) != 0)
				write_reg(REG_MASK_ENABLE, CFG_W'($urandom_range(1, 0)));
			src_gap_max = pick_gap_max();
			sink_gap_max = pick_gap_max();
			frame_pixels = effective_size(img_width, DEF_MAX_WIDTH)
				* effective_size(img_height, DEF_MAX_HEIGHT);
			if (frame_pixels <= 64)
				batch = pixels_to_frame_end() + $urandom_range(2, 0) * frame_pixels;
			else
				batch = $urandom_range(48, 4);
			send_random_pixels(batch);
			sent += batch;
		end
		drain_results();
	endtask

	initial begin : result_sink
		int unsigned gap;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (sink_hold != 0) begin
				gap = sink_hold;
				sink_hold = 0;
			end else begin
				gap = $urandom_range(sink_gap_max, 0);
			end
			if (gap != 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid) @(posedge clk);
			check_result(res_ch.data);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		pix_ch.valid = 1'b0;
		pix_ch.data = '0;
		cfg_we = 1'b0;
		cfg_idx = REG_IMAGE_WIDTH;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_default_geometry();
		test_masking();
		test_size_limits();
		test_output_stall();
		test_random_frames(RANDOM_PIXELS);
		drain_results();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && expected_integrals.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
